/* hdl/assert_macros.svh */
// assertion macros shared by the scheduler rtl
// no dependencies; compiled to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_HOLDS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/wrrtr_pkg.sv */
// types, constants and word layouts for the weighted round-robin task ring
// no dependencies; imported by the top level
package wrrtr_pkg;

    localparam int MAX_TASKS     = 16;
    localparam int PRIORITY_BITS = 7;
    localparam int SLOT_W        = $clog2(MAX_TASKS);
    localparam int COUNT_W       = $clog2(MAX_TASKS + 1);

    typedef logic [SLOT_W-1:0]        t_slot;
    typedef logic [PRIORITY_BITS-1:0] t_prio;
    typedef logic [COUNT_W-1:0]       t_count;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_EXIT   = 3'd2,
        OP_LOCK   = 3'd3,
        OP_UNLOCK = 3'd4,
        OP_SKIP   = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_REFUSED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_T_NEXT,
        S_T_DONE,
        S_C_LINK,
        S_C_DONE,
        S_X_DONE
    } t_state;

    // input word, lowest bits first: opcode, new_priority, zero fill
    typedef struct packed {
        logic [5:0] fill;
        logic [6:0] new_priority;
        logic [2:0] opcode;
    } t_command;

    // result word, lowest bits first: status .. quantum_left
    typedef struct packed {
        logic [6:0] quantum_left;
        logic [4:0] task_count;
        logic [3:0] created_task;
        logic [3:0] running_task;
        logic       switch_slot;
        logic       switched;
        logic [1:0] status;
    } t_result;

endpackage

/* hdl/wrrtr_ram.sv */
// generic link/priority ram: one write port, one registered read port
// per-entry valid bits give entry 0 its reset value and the rest zero
module wrrtr_ram #(
    parameter int               WIDTH = 4,
    parameter int               DEPTH = 16,
    parameter logic [WIDTH-1:0] RST0  = '0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvld;
    logic             r_rzero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rvld  <= 1'b0;
            r_rzero <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld  <= r_vld[i_raddr];
                r_rzero <= (i_raddr == '0);
            end
        end
    end

    // unwritten entries read as their reset value
    assign o_rdata = r_rvld ? r_rdata : (r_rzero ? RST0 : '0);

endmodule

/* hdl/weighted_round_robin_task_ring_core.sv */
// weighted round-robin task ring: one word in, one result word out, one at a time
// lock, unlock, skip, counting tick, refused exit and full create finish in S_EXEC;
// exit adds S_X_DONE, create adds S_C_LINK and S_C_DONE, a switching tick adds
// S_T_NEXT and S_T_DONE; each final state waits while the result register is full
// synchronous active-low reset: idle task alone in the ring, no result pending
`include "assert_macros.svh"

module weighted_round_robin_task_ring_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // opcode[2:0], new_priority[9:3], zero fill
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // status[1:0], switched[2], switch_slot[3],
                                     // running_task[7:4], created_task[11:8],
                                     // task_count[16:12], quantum_left[23:17]
);
    import wrrtr_pkg::*;

    // sequencer and command registers
    t_state     r_state, n_state;
    logic [2:0] r_op, n_op;
    t_prio      r_prio, n_prio;

    // scheduler state kept in flops
    t_slot          r_cur, n_cur;         // running task
    t_slot          r_end, n_end;         // insertion point for create
    t_count         r_count, n_count;     // tasks in the ring
    t_prio          r_quantum, n_quantum;
    logic           r_toggle, n_toggle;   // switch descriptor alternation
    logic           r_lock, n_lock;
    logic           r_exited, n_exited;   // running task has left the ring
    logic [MAX_TASKS-1:0] r_used, n_used;

    // per-item scratch: free slot / next task, and the slot after end
    t_slot r_slot, n_slot;
    t_slot r_aux, n_aux;

    // output register
    logic    r_o_valid, n_o_valid;
    t_result r_result, n_result;

    // ram ports
    logic  nx_we, nx_re, pv_we, pv_re, pr_we, pr_re;
    t_slot nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    t_slot pv_waddr, pv_wdata, pv_raddr, pv_rdata;
    t_slot pr_waddr, pr_raddr;
    t_prio pr_wdata, pr_rdata;

    // lowest free slot
    logic  w_free_found;
    t_slot w_free_slot;

    logic     w_out_free;
    t_command w_cmd;

    assign w_cmd      = t_command'(i_s_tdata);
    assign w_out_free = !r_o_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_result;

    // next links
    wrrtr_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TASKS), .RST0('0)) u_next_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_re    (nx_re),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    // previous links
    wrrtr_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TASKS), .RST0('0)) u_prev_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_re    (pv_re),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    // priorities, idle task gets a quantum of one
    wrrtr_ram #(.WIDTH(PRIORITY_BITS), .DEPTH(MAX_TASKS), .RST0(t_prio'(1))) u_prio_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (pr_we),
        .i_waddr (pr_waddr),
        .i_wdata (pr_wdata),
        .i_re    (pr_re),
        .i_raddr (pr_raddr),
        .o_rdata (pr_rdata)
    );

    // priority encoder over the used mask, lowest index wins
    always_comb begin
        w_free_found = 1'b0;
        w_free_slot  = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_found = 1'b1;
                w_free_slot  = t_slot'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_end     <= '0;
            r_count   <= t_count'(1);
            r_quantum <= '0;
            r_toggle  <= 1'b0;
            r_lock    <= 1'b0;
            r_exited  <= 1'b0;
            r_used    <= MAX_TASKS'(1);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_end     <= n_end;
            r_count   <= n_count;
            r_quantum <= n_quantum;
            r_toggle  <= n_toggle;
            r_lock    <= n_lock;
            r_exited  <= n_exited;
            r_used    <= n_used;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_prio   <= n_prio;
        r_slot   <= n_slot;
        r_aux    <= n_aux;
        r_result <= n_result;
    end

    always_comb begin
        logic       commit;
        t_status    status;
        logic       switched;
        logic       sw_slot;
        t_slot      created;

        commit   = 1'b0;
        status   = STAT_OK;
        switched = 1'b0;
        sw_slot  = 1'b0;
        created  = '0;

        n_state   = r_state;
        n_op      = r_op;
        n_prio    = r_prio;
        n_cur     = r_cur;
        n_end     = r_end;
        n_count   = r_count;
        n_quantum = r_quantum;
        n_toggle  = r_toggle;
        n_lock    = r_lock;
        n_exited  = r_exited;
        n_used    = r_used;
        n_slot    = r_slot;
        n_aux     = r_aux;
        n_o_valid = r_o_valid && !i_m_tready;
        n_result  = r_result;

        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
        nx_re = 1'b0; nx_raddr = r_cur;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
        pv_re = 1'b0; pv_raddr = r_cur;
        pr_we = 1'b0; pr_waddr = '0; pr_wdata = '0;
        pr_re = 1'b0; pr_raddr = nx_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op    = w_cmd.opcode;
                    n_prio  = t_prio'(w_cmd.new_priority);
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_op)
                    OP_TICK: begin
                        if (r_lock || r_quantum != '0) begin
                            // locked: frozen; otherwise spend one tick
                            if (w_out_free) begin
                                if (!r_lock) begin
                                    n_quantum = r_quantum - t_prio'(1);
                                end
                                commit = 1'b1;
                            end
                        end else begin
                            // quantum spent: fetch the next ring entry
                            nx_re    = 1'b1;
                            nx_raddr = r_cur;
                            n_state  = S_T_NEXT;
                        end
                    end
                    OP_CREATE: begin
                        if (!w_free_found) begin
                            if (w_out_free) begin
                                status = STAT_FULL;
                                commit = 1'b1;
                            end
                        end else begin
                            n_slot   = w_free_slot;
                            nx_re    = 1'b1;
                            nx_raddr = r_end;
                            n_state  = S_C_LINK;
                        end
                    end
                    OP_EXIT: begin
                        if (r_cur == '0 || r_exited) begin
                            if (w_out_free) begin
                                status = STAT_REFUSED;
                                commit = 1'b1;
                            end
                        end else begin
                            nx_re    = 1'b1;
                            nx_raddr = r_cur;
                            pv_re    = 1'b1;
                            pv_raddr = r_cur;
                            n_state  = S_X_DONE;
                        end
                    end
                    OP_LOCK: begin
                        if (w_out_free) begin
                            n_lock = 1'b1;
                            commit = 1'b1;
                        end
                    end
                    OP_UNLOCK: begin
                        if (w_out_free) begin
                            n_lock = 1'b0;
                            commit = 1'b1;
                        end
                    end
                    OP_SKIP: begin
                        if (w_out_free) begin
                            n_quantum = '0;
                            n_lock    = 1'b0;
                            commit    = 1'b1;
                        end
                    end
                    default: begin
                        // undefined opcodes complete with no effect
                        if (w_out_free) begin
                            commit = 1'b1;
                        end
                    end
                endcase
            end

            S_T_NEXT: begin
                // next task known; fetch its priority for the quantum reload
                n_slot   = nx_rdata;
                pr_re    = 1'b1;
                pr_raddr = nx_rdata;
                n_state  = S_T_DONE;
            end

            S_T_DONE: begin
                if (w_out_free) begin
                    if (r_exited) begin
                        // leaving an exited task releases its slot
                        n_used[r_cur] = 1'b0;
                        n_exited      = 1'b0;
                    end
                    n_cur     = r_slot;
                    n_quantum = pr_rdata;
                    n_toggle  = !r_toggle;
                    switched  = 1'b1;
                    sw_slot   = !r_toggle;
                    commit    = 1'b1;
                end
            end

            S_C_LINK: begin
                // fill in the new entry, remember the old successor of end
                n_aux    = nx_rdata;
                pr_we    = 1'b1;
                pr_waddr = r_slot;
                pr_wdata = r_prio;
                nx_we    = 1'b1;
                nx_waddr = r_slot;
                nx_wdata = nx_rdata;
                pv_we    = 1'b1;
                pv_waddr = r_slot;
                pv_wdata = r_end;
                n_state  = S_C_DONE;
            end

            S_C_DONE: begin
                if (w_out_free) begin
                    // splice the new entry between end and its old successor
                    pv_we         = 1'b1;
                    pv_waddr      = r_aux;
                    pv_wdata      = r_slot;
                    nx_we         = 1'b1;
                    nx_waddr      = r_end;
                    nx_wdata      = r_slot;
                    n_used[r_slot] = 1'b1;
                    n_end         = r_slot;
                    n_count       = r_count + t_count'(1);
                    created       = r_slot;
                    commit        = 1'b1;
                end
            end

            S_X_DONE: begin
                if (w_out_free) begin
                    // unlink the running task, its own links stay for the next tick
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata;
                    nx_wdata = nx_rdata;
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = pv_rdata;
                    if (r_end == r_cur) begin
                        n_end = nx_rdata;
                    end
                    if (r_count != '0) begin
                        n_count = r_count - t_count'(1);
                    end
                    n_exited = 1'b1;
                    n_lock   = 1'b0;
                    commit   = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (commit) begin
            n_state               = S_IDLE;
            n_o_valid             = 1'b1;
            n_result.status       = status;
            n_result.switched     = switched;
            n_result.switch_slot  = sw_slot;
            n_result.running_task = 4'(n_cur);
            n_result.created_task = 4'(created);
            n_result.task_count   = 5'(n_count);
            n_result.quantum_left = 7'(n_quantum);
        end
    end

    // idle task never gives up its slot
    `ASSERT_HOLDS(a_idle_slot_used, i_clk, i_rst_n, r_used[0])
    // taken slots are the ring members plus an exited task not yet left
    `ASSERT_HOLDS(a_used_matches_count, i_clk, i_rst_n, $countones(r_used) == (int'(r_count) + int'(r_exited)))
    // only a non-idle task can be marked exited
    `ASSERT_IMPLIES(a_exited_not_idle, i_clk, i_rst_n, r_exited, r_cur != '0)
    // one word in flight at a time
    `ASSERT_NEXT(a_single_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

/* tb/weighted_round_robin_task_ring_core_tb.sv */
// self-checking testbench for weighted_round_robin_task_ring_core
// depends on wrrtr_pkg for the command and result word layouts and the opcode codes
// drives command words from a backlog queue and checks every result word against a scheduler model

module weighted_round_robin_task_ring_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrrtr_pkg::*;

    // opcodes with no meaning, the block must ignore them
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int WORDS_PER_PHASE = 270;
    localparam int SETTLE_CYCLES   = 8;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;    // opcode[2:0], new_priority[9:3], zero fill
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // status, switched, switch_slot, running_task,
                                   // created_task, task_count, quantum_left

    logic cmd_taken = 1'b0;        // word on the command bus went in at the last edge
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   error_count    = 0;

    t_command command_backlog[$];
    t_result  result_due[$];

    // scheduler model state
    t_slot  ring_next [MAX_TASKS];
    t_slot  ring_prev [MAX_TASKS];
    t_prio  slot_prio [MAX_TASKS];
    logic [MAX_TASKS-1:0] slot_busy;
    t_slot  run_slot;
    t_slot  tail_slot;
    t_count live_tasks;
    t_prio  ticks_left;
    logic   desc_toggle;
    logic   preempt_locked;
    logic   run_exited;

    weighted_round_robin_task_ring_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idle task alone in the ring
    task automatic reset_scheduler();
        for (int i = 0; i < MAX_TASKS; i++) begin
            ring_next[i] = '0;
            ring_prev[i] = '0;
            slot_prio[i] = '0;
        end
        slot_prio[0]   = t_prio'(1);
        slot_busy      = '0;
        slot_busy[0]   = 1'b1;
        run_slot       = '0;
        tail_slot      = '0;
        live_tasks     = t_count'(1);
        ticks_left     = '0;
        desc_toggle    = 1'b0;
        preempt_locked = 1'b0;
        run_exited     = 1'b0;
    endtask

    // apply one command word to the model and build the result word it causes
    task automatic schedule_command(input t_command cmd, output t_result res);
        t_slot pick;
        t_slot nxt;
        t_slot prv;
        t_slot after;
        bit    found;
        res = '0;
        found = 1'b0;
        pick = '0;
        case (cmd.opcode)
            OP_TICK: begin
                if (!preempt_locked) begin
                    if (ticks_left != 0) begin
                        ticks_left = ticks_left - 1'b1;
                    end else begin
                        nxt = ring_next[run_slot];
                        // leaving an exited task finally frees its slot
                        if (run_exited) begin
                            slot_busy[run_slot] = 1'b0;
                            run_exited = 1'b0;
                        end
                        run_slot    = nxt;
                        ticks_left  = slot_prio[nxt];
                        desc_toggle = ~desc_toggle;
                        res.switched    = 1'b1;
                        res.switch_slot = desc_toggle;
                    end
                end
            end
            OP_CREATE: begin
                // lowest free slot wins, lock does not matter
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (!found && !slot_busy[i]) begin
                        pick  = t_slot'(i);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    res.status = STAT_FULL;
                end else begin
                    after = ring_next[tail_slot];
                    slot_busy[pick]      = 1'b1;
                    slot_prio[pick]      = cmd.new_priority;
                    ring_next[pick]      = after;
                    ring_prev[pick]      = tail_slot;
                    ring_prev[after]     = pick;
                    ring_next[tail_slot] = pick;
                    tail_slot            = pick;
                    live_tasks           = live_tasks + 1'b1;
                    res.created_task     = pick;
                end
            end
            OP_EXIT: begin
                if (run_slot == 0 || run_exited) begin
                    res.status = STAT_REFUSED;
                end else begin
                    prv = ring_prev[run_slot];
                    nxt = ring_next[run_slot];
                    ring_next[prv] = nxt;
                    ring_prev[nxt] = prv;
                    if (tail_slot == run_slot) tail_slot = nxt;
                    if (live_tasks != 0) live_tasks = live_tasks - 1'b1;
                    run_exited     = 1'b1;
                    preempt_locked = 1'b0;
                end
            end
            OP_LOCK:   preempt_locked = 1'b1;
            OP_UNLOCK: preempt_locked = 1'b0;
            OP_SKIP: begin
                ticks_left     = '0;
                preempt_locked = 1'b0;
            end
            default: ;
        endcase
        res.running_task = run_slot;
        res.task_count   = live_tasks;
        res.quantum_left = ticks_left;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // acceptance of command words and checking of result words
    always @(posedge clk) begin
        t_result want;
        t_result got;
        if (!rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                schedule_command(t_command'(s_tdata), want);
                result_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = t_result'(m_tdata);
                if (result_due.size() == 0) begin
                    $display("%0t: result word %h with none expected", $time, m_tdata);
                    error_count++;
                end else begin
                    want = result_due.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("switched", want.switched, got.switched);
                    check_field("switch_slot", want.switch_slot, got.switch_slot);
                    check_field("running_task", want.running_task, got.running_task);
                    check_field("created_task", want.created_task, got.created_task);
                    check_field("task_count", want.task_count, got.task_count);
                    check_field("quantum_left", want.quantum_left, got.quantum_left);
                end
            end
        end
    end

    // command driver and result back-pressure, both change on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || cmd_taken) begin
                if (command_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= command_backlog.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_cmd(input logic [2:0] op, input t_prio prio);
        t_command cmd;
        cmd.fill         = '0;
        cmd.opcode       = op;
        cmd.new_priority = prio;
        command_backlog.push_back(cmd);
    endtask

    // mostly short quanta so switches stay frequent, now and then any value
    function automatic t_prio pick_priority();
        if ($urandom_range(0, 9) < 7) return t_prio'($urandom_range(0, 6));
        return t_prio'($urandom_range(0, 127));
    endfunction

    // one short well-formed sequence, or noise; returns the number of live words
    task automatic queue_random_episode(output int added);
        int n;
        added = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                n = $urandom_range(1, 30);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) push_cmd(OP_SKIP, t_prio'($urandom));
                    else push_cmd(OP_TICK, t_prio'($urandom));
                end
                added = n;
            end
            3, 4: begin
                // bursts long enough to run the ring full
                n = $urandom_range(1, 17);
                repeat (n) push_cmd(OP_CREATE, pick_priority());
                added = n;
            end
            5: begin
                push_cmd(OP_EXIT, t_prio'($urandom));
                added = 1;
                if ($urandom_range(0, 1) == 1) begin
                    push_cmd(OP_EXIT, t_prio'($urandom));
                    added++;
                end
                n = $urandom_range(0, 5);
                repeat (n) push_cmd(OP_TICK, t_prio'($urandom));
                added += n;
            end
            6: begin
                // locked stretch, released by unlock, skip or exit
                push_cmd(OP_LOCK, t_prio'($urandom));
                n = $urandom_range(1, 5);
                repeat (n) push_cmd(OP_TICK, t_prio'($urandom));
                added = n + 2;
                if ($urandom_range(0, 1) == 1) begin
                    push_cmd(OP_CREATE, pick_priority());
                    added++;
                end
                case ($urandom_range(0, 2))
                    0: push_cmd(OP_UNLOCK, t_prio'($urandom));
                    1: push_cmd(OP_SKIP, t_prio'($urandom));
                    default: push_cmd(OP_EXIT, t_prio'($urandom));
                endcase
            end
            7: begin
                push_cmd(OP_SKIP, t_prio'($urandom));
                push_cmd(OP_TICK, t_prio'($urandom));
                added = 2;
            end
            8: begin
                n = $urandom_range(1, 6);
                repeat (n) push_cmd(3'($urandom_range(0, 7)), t_prio'($urandom));
                added = n;
            end
            default: begin
                // drain the ring: exit, give up the quantum, move on
                n = $urandom_range(1, 8);
                repeat (n) begin
                    push_cmd(OP_EXIT, t_prio'($urandom));
                    push_cmd(OP_SKIP, t_prio'($urandom));
                    push_cmd(OP_TICK, t_prio'($urandom));
                end
                added = 3 * n;
            end
        endcase
    endtask

    // sender holds off until every word is in and every result is back
    task automatic wait_for_drain();
        do @(negedge clk);
        while (command_backlog.size() != 0 || s_tvalid || result_due.size() != 0);
    endtask

    initial begin
        int added;
        int queued;
        reset_scheduler();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle task alone, then the special cases in order
        push_cmd(OP_EXIT, t_prio'(0));          // exit of the idle task refused
        push_cmd(OP_TICK, t_prio'(127));        // switch from idle back to idle
        push_cmd(OP_CREATE, t_prio'(127));
        push_cmd(OP_CREATE, t_prio'(0));
        push_cmd(OP_TICK, t_prio'(0));
        push_cmd(OP_TICK, t_prio'(0));          // switch into the long-quantum task
        push_cmd(OP_LOCK, t_prio'(0));
        push_cmd(OP_TICK, t_prio'(0));          // tick while locked does nothing
        push_cmd(OP_CREATE, t_prio'(7'h55));    // create goes through while locked
        push_cmd(OP_UNLOCK, t_prio'(0));
        push_cmd(OP_SKIP, t_prio'(0));
        push_cmd(OP_EXIT, t_prio'(0));
        push_cmd(OP_EXIT, t_prio'(0));          // second exit of the same task refused
        push_cmd(OP_TICK, t_prio'(0));          // leaving the exited task frees its slot
        push_cmd(OP_TICK, t_prio'(0));
        push_cmd(OP_CREATE, t_prio'(7'h2a));    // reuses the freed low slot
        push_cmd(OP_SPARE_6, t_prio'(127));
        push_cmd(OP_SPARE_7, t_prio'(0));
        push_cmd(OP_LOCK, t_prio'(0));
        push_cmd(OP_EXIT, t_prio'(0));          // exit also drops the lock
        push_cmd(OP_TICK, t_prio'(0));
        // fill every slot and then one more for the full status
        repeat (13) push_cmd(OP_CREATE, t_prio'($urandom_range(0, 3)));

        // random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            wait_for_drain();
            @(posedge clk);
            send_idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 33 : 0;
            recv_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 33 : 0;
            queued = 0;
            while (queued < WORDS_PER_PHASE) begin
                queue_random_episode(added);
                queued += added;
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && result_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
